// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except while rst is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tpjq_pkg.sv =====
// ---------------------------------------------------------------------------
// tpjq_pkg
// Types, codes and bus widths shared by the job queue modules.
// ---------------------------------------------------------------------------
package tpjq_pkg;

  // Stream widths
  localparam int TDATA_W = 40;
  localparam int ID_W    = 16;
  localparam int PAGES_W = 16;
  localparam int JOB_W   = ID_W + PAGES_W + 1;

  // Command codes (s_tuser)
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_PROC   = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  // Result status codes (m_tuser)
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Read address select
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_IDX1 = 2'd1;
  localparam logic [1:0] RD_IDX2 = 2'd2;
  localparam logic [1:0] RD_LIST = 2'd3;

  // Result source select
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_INPUT = 2'd1;
  localparam logic [1:0] SRC_RD    = 2'd2;
  localparam logic [1:0] SRC_FOUND = 2'd3;

  // One stored job, id in the low bits
  typedef struct packed {
    logic               urgent;
    logic [PAGES_W-1:0] pages;
    logic [ID_W-1:0]    id;
  } job_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       add_write;
    logic       shift_write;
    logic       pop_head;
    logic       dec_count;
    logic       found_save;
    logic       emit;
    logic [1:0] emit_src;
    logic       emit_last;
  } tpjq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       count_zero;
    logic       full;
    logic       match;
    logic       last_idx;
    logic       last2;
    logic       out_free;
  } tpjq_sts_t;

endpackage

// ===== sv/two_priority_job_queue.sv =====
// ---------------------------------------------------------------------------
// two_priority_job_queue
// Bounded job queue: urgent adds at head, normal adds at tail, process,
// cancel by id and list.
// ---------------------------------------------------------------------------
// Usage:
//   Commands arrive as beats on the s_ group, cmd in s_tuser. Results leave
//   on the m_ group with status in m_tuser and m_tlast on the final result
//   of a command. A successful add gives no result.
//   s_tready is high only while the sequencer is idle, so one command is in
//   work at a time. A cancel on a non-empty queue walks the jobs from the
//   head; the search stops at the first match, then the close-up moves each
//   entry behind it one per cycle over the single memory write port. A list
//   does one memory read, then the output load, for each job.
//   A result appears on m_tvalid the cycle after it is loaded. Jobs live in
//   a ring buffer with one write and one registered read port.
//   Reset empties the queue and drops any result not yet taken; memory
//   contents are not cleared. When the receiver stalls, the result waits in
//   the output register and the sequencer holds until it is taken.
// ---------------------------------------------------------------------------
module two_priority_job_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // job_id[15:0], job_pages[31:16], job_urgent[32], list_reverse[33]
  input  logic [39:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_id[15:0], out_pages[31:16], out_urgent[32]
  output logic [39:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  tpjq_pkg::tpjq_cmd_t cmd;
  tpjq_pkg::tpjq_sts_t sts;

  tpjq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpjq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sv/tpjq_dpath.sv =====
// ---------------------------------------------------------------------------
// tpjq_dpath
// Job ring buffer, head/count/index registers and the output beat register.
// ---------------------------------------------------------------------------
module tpjq_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tpjq_pkg::TDATA_W-1:0] s_tdata,
  input  logic [1:0]                s_tuser,
  input  tpjq_pkg::tpjq_cmd_t       cmd,
  output tpjq_pkg::tpjq_sts_t       sts,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [tpjq_pkg::TDATA_W-1:0] m_tdata,
  output logic [1:0]                m_tuser,
  output logic                      m_tlast
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  tpjq_pkg::job_t mem [QUEUE_DEPTH];
  tpjq_pkg::job_t rd_data;
  tpjq_pkg::job_t req;
  tpjq_pkg::job_t found;
  tpjq_pkg::job_t wr_data;
  tpjq_pkg::job_t out_job;
  logic [1:0]     req_cmd;
  logic           req_rev;
  logic [PW-1:0]  head;
  logic [CW-1:0]  count;
  logic [CW-1:0]  idx;
  logic [PW-1:0]  head_dec;
  logic [PW-1:0]  rd_addr;
  logic [PW-1:0]  wr_addr;
  logic           wr_en;
  logic [SW-1:0]  rd_off;
  logic [SW-1:0]  head_s;
  logic [SW-1:0]  idx_s;
  logic [SW-1:0]  count_s;
  logic [CW-1:0]  list_src;
  logic           out_valid;
  logic [1:0]     out_status;
  logic           out_last;
  logic           out_free;

  // Logical offset from head to ring slot; sum stays below twice the depth
  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] sum);
    if (sum >= DEPTH_S) begin
      wrap = PW'(sum - DEPTH_S);
    end else begin
      wrap = PW'(sum);
    end
  endfunction

  assign head_s   = SW'(head);
  assign idx_s    = SW'(idx);
  assign count_s  = SW'(count);
  assign head_dec = (head == '0) ? LAST_PTR : head - PW'(1);
  assign list_src = req_rev ? (count - CW'(1) - idx) : idx;

  // Read address
  always_comb begin
    case (cmd.rd_sel)
      tpjq_pkg::RD_IDX:  rd_off = idx_s;
      tpjq_pkg::RD_IDX1: rd_off = idx_s + SW'(1);
      tpjq_pkg::RD_IDX2: rd_off = idx_s + SW'(2);
      tpjq_pkg::RD_LIST: rd_off = SW'(list_src);
      default:           rd_off = idx_s;
    endcase
  end
  assign rd_addr = wrap(head_s + rd_off);

  // Write port: add at head or tail, or move one entry toward the head
  always_comb begin
    wr_en   = cmd.add_write | cmd.shift_write;
    wr_data = rd_data;
    wr_addr = wrap(head_s + idx_s);
    if (cmd.add_write) begin
      wr_data = req;
      wr_addr = req.urgent ? head_dec : wrap(head_s + count_s);
    end
  end

  // Job memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.add_write) begin
        if (req.urgent) begin
          head <= head_dec;
        end
        count <= count + CW'(1);
      end
      if (cmd.pop_head) begin
        head  <= wrap(head_s + SW'(1));
        count <= count - CW'(1);
      end
      if (cmd.dec_count) begin
        count <= count - CW'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // Request and cancel capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req     <= tpjq_pkg::job_t'(s_tdata[tpjq_pkg::JOB_W-1:0]);
      req_rev <= s_tdata[tpjq_pkg::JOB_W];
      req_cmd <= s_tuser;
    end
    if (cmd.found_save) begin
      found <= rd_data;
    end
  end

  // Output beat register
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= cmd.emit_last;
      case (cmd.emit_src)
        tpjq_pkg::SRC_INPUT: begin
          out_job    <= req;
          out_status <= tpjq_pkg::ST_FULL;
        end
        tpjq_pkg::SRC_RD: begin
          out_job    <= rd_data;
          out_status <= tpjq_pkg::ST_OK;
        end
        tpjq_pkg::SRC_FOUND: begin
          out_job    <= found;
          out_status <= tpjq_pkg::ST_OK;
        end
        default: begin
          out_job    <= '0;
          out_status <= tpjq_pkg::ST_NONE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(tpjq_pkg::TDATA_W - tpjq_pkg::JOB_W){1'b0}}, out_job};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  // Status to controller
  assign sts.cmd        = req_cmd;
  assign sts.count_zero = (count == '0);
  assign sts.full       = (count == DEPTH_C);
  assign sts.match      = (rd_data.id == req.id);
  assign sts.last_idx   = ((idx_s + SW'(1)) == count_s);
  assign sts.last2      = ((idx_s + SW'(2)) == count_s);
  assign sts.out_free   = out_free;

endmodule

// ===== sv/tpjq_ctrl.sv =====
// ---------------------------------------------------------------------------
// tpjq_ctrl
// Command sequencer: dispatch, cancel search and close-up, list walk.
// ---------------------------------------------------------------------------
module tpjq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  tpjq_pkg::tpjq_sts_t sts,
  output tpjq_pkg::tpjq_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_NONE    = 4'd2;
  localparam logic [3:0] S_FULL    = 4'd3;
  localparam logic [3:0] S_P_EMIT  = 4'd4;
  localparam logic [3:0] S_C_CMP   = 4'd5;
  localparam logic [3:0] S_C_SHIFT = 4'd6;
  localparam logic [3:0] S_C_EMIT  = 4'd7;
  localparam logic [3:0] S_L_RD    = 4'd8;
  localparam logic [3:0] S_L_EMIT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd           = '0;
    cmd.emit_last = 1'b1;
    s_tready      = 1'b0;
    state_next    = state;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.cmd)
          tpjq_pkg::CMD_ADD: begin
            if (sts.full) begin
              state_next = S_FULL;
            end else begin
              cmd.add_write = 1'b1;
              state_next    = S_IDLE;
            end
          end
          tpjq_pkg::CMD_PROC: begin
            if (sts.count_zero) begin
              state_next = S_NONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = tpjq_pkg::RD_IDX;
              state_next = S_P_EMIT;
            end
          end
          tpjq_pkg::CMD_CANCEL: begin
            if (sts.count_zero) begin
              state_next = S_NONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = tpjq_pkg::RD_IDX;
              state_next = S_C_CMP;
            end
          end
          default: begin
            state_next = sts.count_zero ? S_NONE : S_L_RD;
          end
        endcase
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = tpjq_pkg::SRC_NONE;
          state_next   = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = tpjq_pkg::SRC_INPUT;
          state_next   = S_IDLE;
        end
      end
      S_P_EMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = tpjq_pkg::SRC_RD;
          cmd.pop_head = 1'b1;
          state_next   = S_IDLE;
        end
      end
      // One entry compared per cycle, next read issued alongside
      S_C_CMP: begin
        if (sts.match) begin
          cmd.found_save = 1'b1;
          if (sts.last_idx) begin
            cmd.dec_count = 1'b1;
            state_next    = S_C_EMIT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tpjq_pkg::RD_IDX1;
            state_next = S_C_SHIFT;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          if (sts.last_idx) begin
            state_next = S_NONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tpjq_pkg::RD_IDX1;
          end
        end
      end
      // Close the gap: entry idx+1 moves to idx, one per cycle
      S_C_SHIFT: begin
        cmd.shift_write = 1'b1;
        cmd.idx_inc     = 1'b1;
        if (sts.last2) begin
          cmd.dec_count = 1'b1;
          state_next    = S_C_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = tpjq_pkg::RD_IDX2;
        end
      end
      S_C_EMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = tpjq_pkg::SRC_FOUND;
          state_next   = S_IDLE;
        end
      end
      S_L_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tpjq_pkg::RD_LIST;
        state_next = S_L_EMIT;
      end
      S_L_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_src  = tpjq_pkg::SRC_RD;
          cmd.emit_last = sts.last_idx;
          cmd.idx_inc   = 1'b1;
          state_next    = sts.last_idx ? S_IDLE : S_L_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/tpjq_checker.sv =====
// ---------------------------------------------------------------------------
// tpjq_checker
// Port-level checks for the job queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpjq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // Nothing left on the output after reset
  `ASSERT_CLK_RST(a_rst_clears_out, rst |=> !m_tvalid, "result valid after reset")

  // A stalled beat holds
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat moved")

  // Empty and full results close their command
  `ASSERT_CLK(a_status_last, m_tvalid && m_tuser != tpjq_pkg::ST_OK |-> m_tlast, "no last")

  // An empty result carries no job
  `ASSERT_CLK(a_none_zero, m_tvalid && m_tuser == tpjq_pkg::ST_NONE |-> m_tdata == '0, "none data")

  // No new command while a list is still running
  `ASSERT_CLK(a_list_busy, m_tvalid && !m_tlast |-> !s_tready, "accepting during list")

endmodule

bind two_priority_job_queue tpjq_checker u_tpjq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
